// ===== rtl/core/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types and constants of the axis-angle vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [33:0] OneQ30 = 34'sh040000000;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'h20000000;   1: v = 32'h12E4051E;   2: v = 32'h09FB385B;
      3: v = 32'h051111D4;   4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;   7: v = 32'h00517C55;   8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3;  23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } pt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cord_t;

endpackage

// ===== rtl/core/aavr_cordic.sv =====
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined 24-step CORDIC: one micro-rotation per stage, point rides along.
// ----------------------------------------------------------------------------
module aavr_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  aavr_pkg::pt_t            in_pt,
  input  logic [15:0]              in_angle,
  output logic                     out_vld,
  output aavr_pkg::pt_t            out_pt,
  output logic signed [33:0]       out_c,
  output logic signed [33:0]       out_s
);
  localparam int N = aavr_pkg::CordicSteps;
  // Drop the angle bits below the phase resolution.
  localparam logic [31:0] PhMask = (ANGLE_BITS >= 16) ? 32'hFFFFFFFF :
                                   ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);

  logic          vld_r [N+1];
  aavr_pkg::pt_t pt_r  [N+1];
  aavr_pkg::cord_t cs_r [N+1];

  logic [31:0]           ph_w;
  logic [31:0]           phq_w;
  logic                  flip_w;

  always_comb begin
    ph_w   = {in_angle, 16'h0000} & PhMask;
    phq_w  = ph_w + 32'h40000000;
    flip_w = phq_w[31];
  end

  // Stage 0: fold phase into the right half plane.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= in_vld;
    if (en) begin
      pt_r[0]      <= in_pt;
      cs_r[0].x    <= aavr_pkg::CordicGain;
      cs_r[0].y    <= '0;
      cs_r[0].z    <= 34'($signed(flip_w ? ph_w + 32'h80000000 : ph_w));
      cs_r[0].flip <= flip_w;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [33:0] xs_w, ys_w;
    assign xs_w = cs_r[i].x >>> i;
    assign ys_w = cs_r[i].y >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (en) vld_r[i+1] <= vld_r[i];
      if (en) begin
        pt_r[i+1]      <= pt_r[i];
        cs_r[i+1].flip <= cs_r[i].flip;
        if (!cs_r[i].z[33]) begin
          cs_r[i+1].x <= cs_r[i].x - ys_w;
          cs_r[i+1].y <= cs_r[i].y + xs_w;
          cs_r[i+1].z <= cs_r[i].z - aavr_pkg::atan_turn(i);
        end else begin
          cs_r[i+1].x <= cs_r[i].x + ys_w;
          cs_r[i+1].y <= cs_r[i].y - xs_w;
          cs_r[i+1].z <= cs_r[i].z + aavr_pkg::atan_turn(i);
        end
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_pt  = pt_r[N];
  assign out_c   = cs_r[N].flip ? -cs_r[N].x : cs_r[N].x;
  assign out_s   = cs_r[N].flip ? -cs_r[N].y : cs_r[N].y;
endmodule

// ===== rtl/core/aavr_matrix.sv =====
// ----------------------------------------------------------------------------
// aavr_matrix
// Build the nine Q24 rotation matrix entries from c, s and the axis.
// ----------------------------------------------------------------------------
module aavr_matrix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  aavr_pkg::pt_t         in_pt,
  input  logic signed [33:0]    in_c,
  input  logic signed [33:0]    in_s,
  output logic                  out_vld,
  output aavr_pkg::pt_t         out_pt,
  output logic signed [28:0]    out_m [9]
);
  // stage A: axis products, t, s and c
  logic               va_r;
  aavr_pkg::pt_t      pa_r;
  logic signed [31:0] aa_r [6];  // xx yy zz xy xz yz
  logic signed [33:0] t_r, s_r, c_r;
  // stage B: Q58 terms
  logic               vb_r;
  aavr_pkg::pt_t      pb_r;
  logic signed [65:0] ta_r [6];
  logic signed [65:0] sa_r [3];
  logic signed [65:0] cc_r;
  // stage C: rounded entries, up to about +-8.5 with a non-unit axis
  logic               vc_r;
  aavr_pkg::pt_t      pc_r;
  logic signed [28:0] m_r [9];

  logic signed [66:0] q_w [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld; vb_r <= va_r; vc_r <= vb_r;
    end
    if (en) begin
      pa_r <= in_pt;
      aa_r[0] <= in_pt.ax * in_pt.ax;
      aa_r[1] <= in_pt.ay * in_pt.ay;
      aa_r[2] <= in_pt.az * in_pt.az;
      aa_r[3] <= in_pt.ax * in_pt.ay;
      aa_r[4] <= in_pt.ax * in_pt.az;
      aa_r[5] <= in_pt.ay * in_pt.az;
      t_r <= aavr_pkg::OneQ30 - in_c;
      s_r <= in_s;
      c_r <= in_c;
      pb_r <= pa_r;
      for (int k = 0; k < 6; k++) ta_r[k] <= 66'(t_r) * 66'(aa_r[k]);
      sa_r[0] <= 66'(s_r) * 66'(pa_r.ax) <<< 14;
      sa_r[1] <= 66'(s_r) * 66'(pa_r.ay) <<< 14;
      sa_r[2] <= 66'(s_r) * 66'(pa_r.az) <<< 14;
      cc_r <= 66'(c_r) <<< 28;
      pc_r <= pb_r;
      for (int k = 0; k < 9; k++) m_r[k] <= 29'(q_w[k] >>> 34);
    end
  end

  localparam logic signed [66:0] Half = 67'sd1 <<< 33;

  always_comb begin
    q_w[0] = 67'(ta_r[0]) + 67'(cc_r) + Half;
    q_w[1] = 67'(ta_r[3]) + 67'(sa_r[2]) + Half;
    q_w[2] = 67'(ta_r[4]) - 67'(sa_r[1]) + Half;
    q_w[3] = 67'(ta_r[3]) - 67'(sa_r[2]) + Half;
    q_w[4] = 67'(ta_r[1]) + 67'(cc_r) + Half;
    q_w[5] = 67'(ta_r[5]) + 67'(sa_r[0]) + Half;
    q_w[6] = 67'(ta_r[4]) + 67'(sa_r[1]) + Half;
    q_w[7] = 67'(ta_r[5]) - 67'(sa_r[0]) + Half;
    q_w[8] = 67'(ta_r[2]) + 67'(cc_r) + Half;
  end

  assign out_vld = vc_r;
  assign out_pt  = pc_r;
  assign out_m   = m_r;
endmodule

// ===== rtl/core/aavr_apply.sv =====
// ----------------------------------------------------------------------------
// aavr_apply
// Multiply the point by the matrix, round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
module aavr_apply (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  aavr_pkg::pt_t         in_pt,
  input  logic signed [28:0]    in_m [9],
  output logic                  out_vld,
  output logic [95:0]           out_v
);
  logic               va_r, vb_r;
  logic signed [60:0] pr_r [9];
  logic [95:0]        v_r;
  logic signed [62:0] acc_w [3];
  logic signed [38:0] r_w   [3];
  logic signed [31:0] p_w   [3];

  assign p_w[0] = in_pt.px;
  assign p_w[1] = in_pt.py;
  assign p_w[2] = in_pt.pz;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_w[j] = 63'(pr_r[j]) + 63'(pr_r[3+j]) + 63'(pr_r[6+j]) + (63'sd1 <<< 23);
      r_w[j]   = 39'(acc_w[j] >>> 24);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld; vb_r <= va_r;
    end
    if (en) begin
      // pr index: row of p (i) times column (j) -> m[i*3+j]
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr_r[i*3+j] <= 61'(p_w[i]) * 61'(in_m[i*3+j]);
      for (int j = 0; j < 3; j++) begin
        if (r_w[j] > 39'sd2147483647)       v_r[j*32 +: 32] <= 32'h7FFFFFFF;
        else if (r_w[j] < -39'sd2147483648) v_r[j*32 +: 32] <= 32'h80000000;
        else                                v_r[j*32 +: 32] <= r_w[j][31:0];
      end
    end
  end

  assign out_vld = vb_r;
  assign out_v   = v_r;
endmodule

// ===== rtl/core/axis_angle_vector_rotator.sv =====
// Pipeline: input accept to result valid passes 1 phase fold, 24 CORDIC,
// 3 matrix and 2 apply register stages.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds when the output item is stalled.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotator
// Rotates a Q16.16 point about an unnormalized Q2.14 axis by a binary angle
// using the Rodrigues matrix with CORDIC sine and cosine.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotator #(
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // p_x[31:0] p_y[63:32] p_z[95:64] axis_x[111:96] axis_y[127:112]
  // axis_z[143:128] angle[159:144]
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // v_x[31:0] v_y[63:32] v_z[95:64]
  output logic [95:0]  out_tdata
);
  aavr_pkg::pt_t      pt_w, cp_w, mp_w;
  logic               cv_w, mv_w, av_w, en_w;
  logic signed [33:0] c_w, s_w;
  logic signed [28:0] m_w [9];
  logic [95:0]        v_w;

  // Advance whenever the last stage is empty or being taken.
  assign en_w      = !out_tvalid || out_tready;
  assign in_tready = en_w;

  assign pt_w.px = in_tdata[31:0];
  assign pt_w.py = in_tdata[63:32];
  assign pt_w.pz = in_tdata[95:64];
  assign pt_w.ax = in_tdata[111:96];
  assign pt_w.ay = in_tdata[127:112];
  assign pt_w.az = in_tdata[143:128];

  aavr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk, .rst_n, .en(en_w), .in_vld(in_tvalid), .in_pt(pt_w),
    .in_angle(in_tdata[159:144]), .out_vld(cv_w), .out_pt(cp_w),
    .out_c(c_w), .out_s(s_w)
  );

  aavr_matrix u_matrix (
    .clk, .rst_n, .en(en_w), .in_vld(cv_w), .in_pt(cp_w), .in_c(c_w),
    .in_s(s_w), .out_vld(mv_w), .out_pt(mp_w), .out_m(m_w)
  );

  aavr_apply u_apply (
    .clk, .rst_n, .en(en_w), .in_vld(mv_w), .in_pt(mp_w), .in_m(m_w),
    .out_vld(av_w), .out_v(v_w)
  );

  assign out_tvalid = av_w;
  assign out_tdata  = v_w;
endmodule

// ===== tb/tb_axis_angle_vector_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotator
// Drives points, axes and binary angles into the rotator with bursty input
// and a stalling output, and checks every rotated point against a bit-exact
// CORDIC and Rodrigues predictor kept in this file.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotator;

  localparam int AngleBits  = 16;
  localparam int DrainWait  = 80;
  localparam int StallLimit = 20000;
  localparam int NumRandom  = 1700;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } rot_req_t;

  typedef struct packed {
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
  } rot_pt_t;

  // One directed row: the request, and a typed-in result where it is obvious.
  typedef struct {
    rot_req_t req;
    bit       known;
    rot_pt_t  want;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // p_x, p_y, p_z, axis_x, axis_y, axis_z, angle (lowest bits first)
  logic [159:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // v_x, v_y, v_z (lowest bits first)
  logic [95:0]  out_tdata;

  rot_pt_t   rotated_q[$];
  int        errors;
  int        idle_cycles;
  bit        feeding_done;
  dir_row_t  dir_rows[$];

  axis_angle_vector_rotator #(.ANGLE_BITS(AngleBits)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Arithmetic right shift of a 128-bit value; >>> already floors.
  function automatic logic signed [127:0] fshr(input logic signed [127:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [127:0] rnd_shr(input logic signed [127:0] v,
                                                  input int n);
    logic signed [127:0] half;
    half = 128'sd1 <<< (n - 1);
    return fshr(v + half, n);
  endfunction

  // CORDIC sine and cosine in Q1.30 for a binary angle.
  task automatic cordic_sincos(input logic [15:0] ang,
                               output logic signed [127:0] c,
                               output logic signed [127:0] s);
    logic [31:0] a32;
    logic [31:0] ph;
    logic        flip;
    logic signed [127:0] x, y, z, nx;
    logic signed [127:0] step_atan;
    a32 = {16'd0, ang};
    if (AngleBits >= 16) a32 = a32 << (AngleBits - 16);
    else a32 = a32 >> (16 - AngleBits);
    ph = a32 << (32 - AngleBits);
    flip = ph[31] ^ ph[30];  // top bit of ph + quarter turn
    if (flip) ph = ph + 32'h80000000;
    z = $signed(ph);
    x = 128'sh26DD3B6A;
    y = '0;
    for (int i = 0; i < 24; i++) begin
      step_atan = aavr_pkg::atan_turn(i);
      if (z >= 0) begin
        nx = x - fshr(y, i);
        y  = y + fshr(x, i);
        z  = z - step_atan;
      end else begin
        nx = x + fshr(y, i);
        y  = y - fshr(x, i);
        z  = z + step_atan;
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic signed [31:0] sat_q16(input logic signed [127:0] acc);
    logic signed [127:0] r;
    r = rnd_shr(acc, 24);
    if (r > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -128'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  // Rodrigues rotation of one point.
  task automatic rotate_point(input rot_req_t r, output rot_pt_t v);
    logic signed [127:0] c, s, t, cc, ax, ay, az, px, py, pz;
    logic signed [127:0] sx, sy, sz, txy, txz, tyz;
    logic signed [127:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    cordic_sincos(r.angle, c, s);
    ax = r.ax; ay = r.ay; az = r.az;
    px = r.px; py = r.py; pz = r.pz;
    t  = (128'sd1 <<< 30) - c;
    cc = c <<< 28;
    sx = (s * ax) <<< 14;
    sy = (s * ay) <<< 14;
    sz = (s * az) <<< 14;
    txy = t * ax * ay;
    txz = t * ax * az;
    tyz = t * ay * az;
    m00 = rnd_shr(t * ax * ax + cc, 34);
    m01 = rnd_shr(txy + sz, 34);
    m02 = rnd_shr(txz - sy, 34);
    m10 = rnd_shr(txy - sz, 34);
    m11 = rnd_shr(t * ay * ay + cc, 34);
    m12 = rnd_shr(tyz + sx, 34);
    m20 = rnd_shr(txz + sy, 34);
    m21 = rnd_shr(tyz - sx, 34);
    m22 = rnd_shr(t * az * az + cc, 34);
    v.vx = sat_q16(px * m00 + py * m10 + pz * m20);
    v.vy = sat_q16(px * m01 + py * m11 + pz * m21);
    v.vz = sat_q16(px * m02 + py * m12 + pz * m22);
  endtask

  function automatic rot_req_t mk_req(input logic [31:0] px, py, pz,
                                      input logic [15:0] ax, ay, az, ang);
    rot_req_t r;
    r.px = px; r.py = py; r.pz = pz;
    r.ax = ax; r.ay = ay; r.az = az; r.angle = ang;
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
    endcase
  endfunction

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(0, 4))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      default: return 16'($signed($urandom_range(0, 16'h8000)) - 32'sh4000);
    endcase
  endfunction

  function automatic rot_req_t rnd_req();
    logic [15:0] ang;
    ang = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3) * 16'h4000)
                                       : 16'($urandom());
    return mk_req(rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_axis(), rnd_axis(), rnd_axis(), ang);
  endfunction

  // Present one item; the item stays up until taken.
  task automatic send_item(input rot_req_t r);
    rot_pt_t v;
    rotate_point(r, v);
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
    rotated_q.push_back(v);
  endtask

  task automatic add_row(input rot_req_t r, input bit known, input rot_pt_t w);
    dir_row_t d;
    d.req = r; d.known = known; d.want = w;
    dir_rows.push_back(d);
  endtask

  // Stimulus: directed table, then random bursts.
  initial begin
    rot_pt_t  zero_pt;
    rot_pt_t  v;
    int       burst;
    zero_pt = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    feeding_done = 1'b0;

    // Zero point always gives zero; angle zero with unit x axis is identity.
    add_row(mk_req(0, 0, 0, 16'h4000, 0, 0, 16'h1234), 1, zero_pt);
    add_row(mk_req(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF), 1, zero_pt);
    add_row(mk_req(32'h00010000, 32'h00020000, 32'h00030000, 16'h4000, 0, 0, 0),
            1, '{32'sh00030000, 32'sh00020000, 32'sh00010000});
    // Extremes of the fields, quadrant edges, non-unit axes, saturation.
    add_row(mk_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000), 0, zero_pt);
    add_row(mk_req(32'h80000000, 32'h80000000, 32'h80000000,
                   16'h8000, 16'h8000, 16'h8000, 16'hE000), 0, zero_pt);
    add_row(mk_req(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   16'h7FFF, 16'h8000, 0, 16'h8000), 0, zero_pt);
    add_row(mk_req(32'h00010000, 0, 0, 0, 0, 16'h4000, 16'h4000), 0, zero_pt);
    add_row(mk_req(32'h00010000, 0, 0, 0, 0, 16'h4000, 16'h3FFF), 0, zero_pt);
    add_row(mk_req(32'h00010000, 0, 0, 0, 0, 16'h4000, 16'hC000), 0, zero_pt);
    add_row(mk_req(32'h00010000, 0, 0, 0, 0, 16'h4000, 16'hBFFF), 0, zero_pt);
    add_row(mk_req(0, 32'h00010000, 0, 16'h4000, 0, 0, 16'h8000), 0, zero_pt);
    add_row(mk_req(0, 0, 32'h00010000, 0, 16'hC000, 0, 16'h7FFF), 0, zero_pt);
    add_row(mk_req(32'hFFFFFFFF, 1, 32'hFFFF0000, 16'h0001, 16'hFFFF, 0,
                   16'h0001), 0, zero_pt);
    add_row(mk_req(32'h40000000, 32'hC0000000, 32'h40000000,
                   16'h2000, 16'h2000, 16'h2000, 16'h6000), 0, zero_pt);
    add_row(mk_req(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                   16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 0, zero_pt);
    add_row(mk_req(32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                   16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 0, zero_pt);
    add_row(mk_req(32'h00008000, 32'hFFFF8000, 32'h00000001,
                   16'h0000, 16'h0000, 16'h0000, 16'hFFFF), 0, zero_pt);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        rotate_point(dir_rows[i].req, v);
        if (v !== dir_rows[i].want) begin
          $error("directed row %0d: predictor gives %h, table gives %h",
                 i, v, dir_rows[i].want);
          errors++;
        end
      end
      send_item(dir_rows[i].req);
    end

    // Random bursts, most of them followed by a random gap.
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) send_item(rnd_req());
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    feeding_done = 1'b1;
  end

  // Receiver: alternate between free-flowing and stalling stretches.
  initial begin
    int mode_left;
    int mode;
    out_tready = 1'b0;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    rot_pt_t got;
    rot_pt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rotated_q.size() == 0) begin
        $error("result %h with nothing expected", got);
        errors++;
      end else begin
        want = rotated_q.pop_front();
        if (got.vx !== want.vx) begin
          $error("v_x: expected %h, actual %h", want.vx, got.vx); errors++;
        end
        if (got.vy !== want.vy) begin
          $error("v_y: expected %h, actual %h", want.vy, got.vy); errors++;
        end
        if (got.vz !== want.vz) begin
          $error("v_z: expected %h, actual %h", want.vz, got.vz); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run: drain, wait out the pipeline, then report.
  initial begin
    fork
      begin
        wait (feeding_done && rotated_q.size() == 0);
        repeat (DrainWait) @(posedge clk);
        if (errors == 0 && rotated_q.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
      end
      begin
        wait (idle_cycles >= StallLimit);
        $display("TB_ERROR");
      end
    join_any
    $finish;
  end

endmodule
